/* rtl/zsf_pkg.sv */
`timescale 1ns / 1ps
// Package for the zlib stored-block stream framer.
// Byte codes, stream kinds, emit positions and the per-beat item record.
// No dependencies.
package zsf_pkg;

	// default width of the stream byte counters
	localparam int LENGTH_BITS_DEF = 24;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TOTAL_LEN_W = 24;
	localparam logic [0:0] REG_TOTAL_LENGTH = 1'b0;

	// zlib / deflate constants
	localparam logic [7:0] ZLIB_CMF = 8'h78;
	localparam logic [7:0] ZLIB_FLG = 8'hda;
	localparam logic [7:0] BFINAL_STORED = 8'h01;
	localparam logic [7:0] BLOCK_STORED = 8'h00;
	localparam logic [15:0] MAX_STORED = 16'hffff;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	// byte_kind codes
	localparam logic [1:0] KIND_ZHDR = 2'd0;
	localparam logic [1:0] KIND_BHDR = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;
	localparam logic [1:0] KIND_TRAILER = 2'd3;

	// emit positions within one item's run of output beats
	localparam logic [3:0] POS_ZHDR0 = 4'd0;
	localparam logic [3:0] POS_ZHDR1 = 4'd1;
	localparam logic [3:0] POS_BTYPE = 4'd2;
	localparam logic [3:0] POS_LEN0 = 4'd3;
	localparam logic [3:0] POS_LEN1 = 4'd4;
	localparam logic [3:0] POS_NLEN0 = 4'd5;
	localparam logic [3:0] POS_NLEN1 = 4'd6;
	localparam logic [3:0] POS_DATA = 4'd7;
	localparam logic [3:0] POS_TRL0 = 4'd8;
	localparam logic [3:0] POS_TRL1 = 4'd9;
	localparam logic [3:0] POS_TRL2 = 4'd10;
	localparam logic [3:0] POS_TRL3 = 4'd11;

	// everything needed to emit the beats caused by one input byte
	typedef struct packed {
		logic        zlib_hdr;
		logic        blk_hdr;
		logic        final_blk;
		logic [15:0] blk_len;
		logic [7:0]  data;
		logic        trailer;
		logic [15:0] adler_hi;
		logic [15:0] adler_lo;
	} item_t;

endpackage

/* rtl/zlib_stored_stream_framer_core.sv */
`timescale 1ns / 1ps
// zlib stored-block stream framer, top level.
// Depends on zsf_pkg (constants and the item record).
//
// Each accepted input beat is one raw byte. The framer emits the matching zlib
// stream bytes one per output beat: header 0x78 0xDA before a stream's first
// byte, a five-byte stored-block header (BFINAL, LEN, NLEN) every 65535 bytes,
// the byte itself, and the big-endian Adler-32 after the stream's last byte,
// then re-arms. total_length (APB register 0) is sampled on a stream's first
// byte; zero counts as one. Rate: one input beat per cycle while each byte makes
// a single output beat and m_tready is high; a byte that opens a stream or a
// block or closes a stream makes 5 to 12 output beats, as the port moves one byte
// a cycle. All state update, including both Adler-32 modulo steps, happens at the
// input beat; the computed item then waits in a holding stage (_s1) while the
// emit stage (_s2) walks the previous item, so input and output are decoupled
// by one item.
module zlib_stored_stream_framer_core
	import zsf_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// raw byte input
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] data_byte
	// zlib stream output
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // [7:0] out_byte
	output logic                  m_tlast,  // last_of_run
	output logic [2:0]            m_tuser   // [1:0] byte_kind, [2] end_of_stream
);

	// ---------------------------------------------------------------- config
	logic [TOTAL_LEN_W-1:0] total_length_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[CFG_ADDR_W-1:2] == REG_TOTAL_LENGTH);
	assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TOTAL_LENGTH) ?
		CFG_DATA_W'(total_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q <= TOTAL_LEN_W'(1);
		end else if (cfg_wr) begin
			total_length_q <= pwdata[TOTAL_LEN_W-1:0];
		end
	end

	// ---------------------------------------------------------- stream state
	logic                   started_q;
	logic [LENGTH_BITS-1:0] total_left_q;
	logic [15:0]            block_left_q;
	logic [15:0]            sum_low_q;
	logic [15:0]            sum_high_q;

	// handshake / pipeline control
	logic  valid_s1, valid_s2;
	item_t item_s1, item_s2;
	logic  [3:0] pos_s2;
	logic  in_fire, out_fire, out_last, s2_free, load_s2;

	// values in force for this byte (stream start folded in)
	logic [LENGTH_BITS-1:0] len_samp;
	logic [LENGTH_BITS-1:0] tl_eff;
	logic [15:0]            bl_eff;
	logic [15:0]            sl_eff;
	logic [15:0]            sh_eff;
	logic                   need_blk;
	logic                   final_blk;
	logic [15:0]            blk_len;
	logic [LENGTH_BITS-1:0] tl_next;
	logic [15:0]            bl_next;
	logic [16:0]            low_sum, high_sum;
	logic [15:0]            low_new, high_new;
	logic                   stream_end;
	item_t                  item_new;

	always_comb begin
		len_samp = LENGTH_BITS'(total_length_q);
		if (!started_q) begin
			tl_eff = (len_samp == '0) ? LENGTH_BITS'(1) : len_samp;
			bl_eff = '0;
			sl_eff = 16'd1;
			sh_eff = '0;
		end else begin
			tl_eff = total_left_q;
			bl_eff = block_left_q;
			sl_eff = sum_low_q;
			sh_eff = sum_high_q;
		end

		need_blk  = (bl_eff == '0);
		final_blk = (tl_eff <= LENGTH_BITS'(MAX_STORED));
		blk_len   = final_blk ? tl_eff[15:0] : MAX_STORED;

		bl_next = (need_blk ? blk_len : bl_eff) - 16'd1;
		tl_next = tl_eff - LENGTH_BITS'(1);
		stream_end = (tl_next == '0);

		// Adler-32: both sums stay below the modulus, so one subtract each
		low_sum  = {1'b0, sl_eff} + 17'(s_tdata);
		low_new  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
		high_sum = {1'b0, sh_eff} + {1'b0, low_new};
		high_new = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];

		item_new.zlib_hdr  = !started_q;
		item_new.blk_hdr   = need_blk;
		item_new.final_blk = final_blk;
		item_new.blk_len   = blk_len;
		item_new.data      = s_tdata;
		item_new.trailer   = stream_end;
		item_new.adler_hi  = high_new;
		item_new.adler_lo  = low_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			total_left_q <= '0;
			block_left_q <= '0;
			sum_low_q    <= 16'd1;
			sum_high_q   <= '0;
		end else if (in_fire) begin
			if (stream_end) begin
				// re-arm for the next stream
				started_q    <= 1'b0;
				total_left_q <= '0;
				block_left_q <= '0;
				sum_low_q    <= 16'd1;
				sum_high_q   <= '0;
			end else begin
				started_q    <= 1'b1;
				total_left_q <= tl_next;
				block_left_q <= bl_next;
				sum_low_q    <= low_new;
				sum_high_q   <= high_new;
			end
		end
	end

	// ------------------------------------------------------------- pipeline
	logic [3:0] last_pos;
	logic [3:0] start_pos;
	logic [3:0] next_pos;

	assign last_pos  = item_s2.trailer ? POS_TRL3 : POS_DATA;
	assign out_last  = valid_s2 && (pos_s2 == last_pos);
	assign out_fire  = m_tvalid && m_tready;
	assign s2_free   = !valid_s2 || (out_fire && out_last);
	assign load_s2   = valid_s1 && s2_free;
	assign s_tready  = !valid_s1 || load_s2;
	assign in_fire   = s_tvalid && s_tready;

	assign start_pos = item_s1.zlib_hdr ? POS_ZHDR0 :
		(item_s1.blk_hdr ? POS_BTYPE : POS_DATA);

	always_comb begin
		case (pos_s2)
			POS_ZHDR1: next_pos = item_s2.blk_hdr ? POS_BTYPE : POS_DATA;
			default:   next_pos = pos_s2 + 4'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_s2   <= POS_ZHDR0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end

			if (load_s2) begin
				valid_s2 <= 1'b1;
				pos_s2   <= start_pos;
			end else if (out_fire) begin
				if (out_last) begin
					valid_s2 <= 1'b0;
				end else begin
					pos_s2 <= next_pos;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_new;
		end
		if (load_s2) begin
			item_s2 <= item_s1;
		end
	end

	// ---------------------------------------------------------------- output
	logic [7:0] out_byte;
	logic [1:0] byte_kind;

	always_comb begin
		case (pos_s2)
			POS_ZHDR0: begin
				out_byte  = ZLIB_CMF;
				byte_kind = KIND_ZHDR;
			end
			POS_ZHDR1: begin
				out_byte  = ZLIB_FLG;
				byte_kind = KIND_ZHDR;
			end
			POS_BTYPE: begin
				out_byte  = item_s2.final_blk ? BFINAL_STORED : BLOCK_STORED;
				byte_kind = KIND_BHDR;
			end
			POS_LEN0: begin
				out_byte  = item_s2.blk_len[7:0];
				byte_kind = KIND_BHDR;
			end
			POS_LEN1: begin
				out_byte  = item_s2.blk_len[15:8];
				byte_kind = KIND_BHDR;
			end
			POS_NLEN0: begin
				out_byte  = ~item_s2.blk_len[7:0];
				byte_kind = KIND_BHDR;
			end
			POS_NLEN1: begin
				out_byte  = ~item_s2.blk_len[15:8];
				byte_kind = KIND_BHDR;
			end
			POS_DATA: begin
				out_byte  = item_s2.data;
				byte_kind = KIND_DATA;
			end
			POS_TRL0: begin
				out_byte  = item_s2.adler_hi[15:8];
				byte_kind = KIND_TRAILER;
			end
			POS_TRL1: begin
				out_byte  = item_s2.adler_hi[7:0];
				byte_kind = KIND_TRAILER;
			end
			POS_TRL2: begin
				out_byte  = item_s2.adler_lo[15:8];
				byte_kind = KIND_TRAILER;
			end
			POS_TRL3: begin
				out_byte  = item_s2.adler_lo[7:0];
				byte_kind = KIND_TRAILER;
			end
			default: begin
				out_byte  = item_s2.data;
				byte_kind = KIND_DATA;
			end
		endcase
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = out_byte;
	assign m_tlast  = out_last;
	assign m_tuser  = {item_s2.trailer && (pos_s2 == POS_TRL3), byte_kind};

endmodule
